// File: design/cvg_pkg.sv
package cvg_pkg;

   // Field widths
   localparam int DistW  = 32;
   localparam int ThrW   = 31;
   localparam int CoefW  = 32;
   localparam int RateW  = 16;
   localparam int ScaleW = 17;
   localparam int IdxW   = 4;

   localparam logic [ScaleW-1:0] FULL_SCALE = 17'd65536;
   localparam logic [31:0]       LOG2E_Q16  = 32'd94548;

   // Register indexes
   localparam logic [IdxW-1:0] REG_MODE        = 4'd0;
   localparam logic [IdxW-1:0] REG_SCENE_THR   = 4'd1;
   localparam logic [IdxW-1:0] REG_SELF_THR    = 4'd2;
   localparam logic [IdxW-1:0] REG_SCENE_COEF  = 4'd3;
   localparam logic [IdxW-1:0] REG_SELF_COEF   = 4'd4;
   localparam logic [IdxW-1:0] REG_MIN_DIST    = 4'd5;
   localparam logic [IdxW-1:0] REG_SAFETY      = 4'd6;
   localparam logic [IdxW-1:0] REG_CHECK_RATE  = 4'd7;

   // Register reset values
   localparam logic [ThrW-1:0]  RST_SCENE_THR  = 31'd19661;
   localparam logic [ThrW-1:0]  RST_SELF_THR   = 31'd6554;
   localparam logic [CoefW-1:0] RST_SCENE_COEF = 32'd1509221;
   localparam logic [CoefW-1:0] RST_SELF_COEF  = 32'd4527660;
   localparam logic [ThrW-1:0]  RST_MIN_DIST   = 31'd0;
   localparam logic [31:0]      RST_SAFETY     = 32'd98304;
   localparam logic [RateW-1:0] RST_CHECK_RATE = 16'd100;

   // 2^(-k/16) in Q1.16, k = 0..16
   function automatic logic [16:0] pow2_neg(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd62757;
         5'd2:    v = 17'd60096;
         5'd3:    v = 17'd57548;
         5'd4:    v = 17'd55109;
         5'd5:    v = 17'd52773;
         5'd6:    v = 17'd50535;
         5'd7:    v = 17'd48392;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd44376;
         5'd10:   v = 17'd42495;
         5'd11:   v = 17'd40693;
         5'd12:   v = 17'd38968;
         5'd13:   v = 17'd37316;
         5'd14:   v = 17'd35734;
         5'd15:   v = 17'd34219;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction

endpackage

// File: design/collision_velocity_governor.sv
// Collision velocity governor: one transfer on req_ gives one velocity scale
// (Q1.16, 65536 is full speed) on rsp_. A reported contact skips to the final
// step with a scale of 0. In threshold mode (mode 0) each clearance below its
// threshold is run through an approximated exp(-coef*(thr-d)) and the smaller
// cap wins; a clearance at or above its threshold skips the exponential. In
// stop mode (mode 1) the nearer clearance and its change since the last
// stop-mode tick decide between 0 and full speed; the exact time-to-collision
// compare runs only when the clearance shrinks and is not below the minimum.
// The final step waits until the output register is free. All
// products go through one shared 32x32 multiplier with a registered result,
// stepped by a small sequencer, so one item is in flight at a time and
// req_ready is low until the result has been moved into the output register.
// That register lets the next transfer in while a result still waits on
// rsp_ready. Configuration goes through csr_ (always ready) and must be
// written while the block is idle; indexes beyond 7 are ignored.
module collision_velocity_governor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [cvg_pkg::DistW-1:0] req_scene_distance,
   input  logic signed [cvg_pkg::DistW-1:0] req_self_distance,
   input  logic                            req_in_collision,
   input  logic [31:0]                     req_stop_time,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cvg_pkg::ScaleW-1:0]      rsp_speed_ratio,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cvg_pkg::IdxW-1:0]        csr_index,
   input  logic [31:0]                     csr_data
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_EXP0  = 5'd1;
   localparam logic [4:0] ST_EXP1  = 5'd2;
   localparam logic [4:0] ST_EXP2  = 5'd3;
   localparam logic [4:0] ST_EXP3  = 5'd4;
   localparam logic [4:0] ST_EXP4  = 5'd5;
   localparam logic [4:0] ST_EXP5  = 5'd6;
   localparam logic [4:0] ST_EXP6  = 5'd7;
   localparam logic [4:0] ST_STOP0 = 5'd8;
   localparam logic [4:0] ST_STOP1 = 5'd9;
   localparam logic [4:0] ST_STOP2 = 5'd10;
   localparam logic [4:0] ST_STOP3 = 5'd11;
   localparam logic [4:0] ST_STOP4 = 5'd12;
   localparam logic [4:0] ST_STOP5 = 5'd13;
   localparam logic [4:0] ST_STOP6 = 5'd14;
   localparam logic [4:0] ST_STOP7 = 5'd15;
   localparam logic [4:0] ST_STOP8 = 5'd16;
   localparam logic [4:0] ST_STOP9 = 5'd17;
   localparam logic [4:0] ST_DONE  = 5'd18;

   // Configuration registers
   logic                          mode_ff;
   logic [cvg_pkg::ThrW-1:0]      scene_thr_ff, self_thr_ff, min_dist_ff;
   logic [cvg_pkg::CoefW-1:0]     scene_coef_ff, self_coef_ff;
   logic [31:0]                   safety_ff;
   logic [cvg_pkg::RateW-1:0]     check_rate_ff;

   // Sequencer and datapath registers
   logic [4:0]         state_ff, state_in;
   logic               side_ff, side_in;
   logic signed [31:0] scene_ff, scene_in, self_ff, self_in;
   logic [31:0]        stop_ff, stop_in;
   logic [16:0]        scale_ff, scale_in;
   logic [19:0]        y_ff, y_in;
   logic               zero_ff, zero_in;
   logic [4:0]         n_ff, n_in;
   logic [11:0]        r_ff, r_in;
   logic [16:0]        v0_ff, v0_in, v_ff, v_in;
   logic [15:0]        dv_ff, dv_in;
   logic signed [31:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [31:0]        absdiff_ff, absdiff_in, acur_ff, acur_in;
   logic [47:0]        den_ff, den_in;
   logic [63:0]        p1_ff, p1_in;
   logic [111:0]       acc_ff, acc_in;
   logic [63:0]        prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [16:0]        rsp_scale_ff, rsp_scale_in;

   // Shared multiplier operands
   logic [31:0] mul_a, mul_b;

   // Side selection for the exponential pass
   logic signed [31:0] d_sel;
   logic [30:0]        t_sel;
   logic [31:0]        c_sel;
   logic signed [32:0] d_x, t_x, m_x;
   logic               below;
   logic [15:0]        rate;

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_ratio = rsp_scale_ff;

   assign rate  = (check_rate_ff == 16'd0) ? 16'd1 : check_rate_ff;
   assign d_sel = side_ff ? self_ff : scene_ff;
   assign t_sel = side_ff ? self_thr_ff : scene_thr_ff;
   assign c_sel = side_ff ? self_coef_ff : scene_coef_ff;
   assign d_x   = {d_sel[31], d_sel};
   assign t_x   = {2'b00, t_sel};
   assign m_x   = t_x - d_x;
   assign below = (d_x < t_x);

   // Operand select for the one multiplier, one product per cycle
   always_comb begin
      unique case (state_ff)
         ST_EXP0: begin
            mul_a = c_sel;
            mul_b = m_x[31:0];
         end
         ST_EXP2: begin
            mul_a = {12'd0, y_ff};
            mul_b = cvg_pkg::LOG2E_Q16;
         end
         ST_EXP4: begin
            mul_a = {16'd0, dv_ff};
            mul_b = {20'd0, r_ff};
         end
         ST_STOP2: begin
            mul_a = absdiff_ff;
            mul_b = {16'd0, rate};
         end
         ST_STOP3: begin
            mul_a = safety_ff;
            mul_b = stop_ff;
         end
         ST_STOP4: begin
            mul_a = prod_ff[31:0];
            mul_b = den_ff[31:0];
         end
         ST_STOP5: begin
            mul_a = p1_ff[31:0];
            mul_b = {16'd0, den_ff[47:32]};
         end
         ST_STOP6: begin
            mul_a = p1_ff[63:32];
            mul_b = den_ff[31:0];
         end
         ST_STOP7: begin
            mul_a = p1_ff[63:32];
            mul_b = {16'd0, den_ff[47:32]};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      logic [35:0]        ysum;
      logic [37:0]        zsum;
      logic [21:0]        z;
      logic [28:0]        isum;
      logic [17:0]        half, vsum;
      logic [16:0]        cap;
      logic signed [32:0] cur_x, prev_x, diff;
      logic               next_side;

      state_in     = state_ff;
      side_in      = side_ff;
      scene_in     = scene_ff;
      self_in      = self_ff;
      stop_in      = stop_ff;
      scale_in     = scale_ff;
      y_in         = y_ff;
      zero_in      = zero_ff;
      n_in         = n_ff;
      r_in         = r_ff;
      v0_in        = v0_ff;
      dv_in        = dv_ff;
      v_in         = v_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      absdiff_in   = absdiff_ff;
      acur_in      = acur_ff;
      den_in       = den_ff;
      p1_in        = p1_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_scale_in = rsp_scale_ff;

      ysum      = prod_ff[35:0] + 36'd32768;
      zsum      = {1'b0, prod_ff[36:0]} + 38'd32768;
      z         = zsum[37:16];
      isum      = prod_ff[28:0] + 29'd2048;
      half      = (18'd1 << n_ff) >> 1;
      vsum      = {1'b0, v_ff} + half;
      cap       = zero_ff ? 17'd0 : 17'(vsum >> n_ff);
      cur_x     = {cur_ff[31], cur_ff};
      prev_x    = {prev_ff[31], prev_ff};
      diff      = cur_x - prev_x;
      next_side = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               scene_in = req_scene_distance;
               self_in  = req_self_distance;
               stop_in  = req_stop_time;
               side_in  = 1'b0;
               scale_in = cvg_pkg::FULL_SCALE;
               if (req_in_collision) begin
                  scale_in = 17'd0;
                  state_in = ST_DONE;
               end else if (mode_ff) begin
                  state_in = ST_STOP0;
               end else begin
                  state_in = ST_EXP0;
               end
            end
         end
         // Threshold mode: one pass per side, product coef*(thr-d) issued here
         ST_EXP0: begin
            if (below) begin
               state_in = ST_EXP1;
            end else begin
               next_side = 1'b1;
            end
         end
         ST_EXP1: begin
            zero_in  = (prod_ff[63:32] >= 32'd12);
            y_in     = ysum[35:16];
            state_in = ST_EXP2;
         end
         ST_EXP2: begin
            state_in = ST_EXP3;
         end
         ST_EXP3: begin
            // z = y*log2(e): integer part is the shift, fraction indexes the table
            if (z[21:16] >= 6'd17) begin
               zero_in = 1'b1;
            end
            n_in     = z[20:16];
            r_in     = z[11:0];
            v0_in    = cvg_pkg::pow2_neg({1'b0, z[15:12]});
            dv_in    = 16'(cvg_pkg::pow2_neg({1'b0, z[15:12]})
                         - cvg_pkg::pow2_neg({1'b0, z[15:12]} + 5'd1));
            state_in = ST_EXP4;
         end
         ST_EXP4: begin
            state_in = ST_EXP5;
         end
         ST_EXP5: begin
            v_in     = v0_ff - isum[28:12];
            state_in = ST_EXP6;
         end
         ST_EXP6: begin
            if (cap < scale_ff) begin
               scale_in = cap;
            end
            next_side = 1'b1;
         end
         // Stop mode
         ST_STOP0: begin
            cur_in   = (scene_ff < self_ff) ? scene_ff : self_ff;
            state_in = ST_STOP1;
         end
         ST_STOP1: begin
            prev_in = cur_ff;
            if ((cur_x < $signed({2'b00, min_dist_ff})) && (diff <= 33'sd0)) begin
               scale_in = 17'd0;
               state_in = ST_DONE;
            end else if (diff[32]) begin
               absdiff_in = 32'(-diff);
               acur_in    = cur_ff[31] ? 32'(-cur_x) : cur_ff;
               state_in   = ST_STOP2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_STOP2: begin
            state_in = ST_STOP3;
         end
         ST_STOP3: begin
            den_in   = prod_ff[47:0];
            state_in = ST_STOP4;
         end
         ST_STOP4: begin
            p1_in    = prod_ff;
            acc_in   = 112'd0;
            state_in = ST_STOP5;
         end
         ST_STOP5: begin
            acc_in   = acc_ff + {48'd0, prod_ff};
            state_in = ST_STOP6;
         end
         ST_STOP6: begin
            acc_in   = acc_ff + {16'd0, prod_ff, 32'd0};
            state_in = ST_STOP7;
         end
         ST_STOP7: begin
            acc_in   = acc_ff + {16'd0, prod_ff, 32'd0};
            state_in = ST_STOP8;
         end
         ST_STOP8: begin
            acc_in   = acc_ff + {prod_ff[47:0], 64'd0};
            state_in = ST_STOP9;
         end
         ST_STOP9: begin
            // Too fast when |cur| * 2^32 < safety * stop * |diff| * rate
            if ((acc_ff[111:64] != 48'd0) || ({acur_ff, 32'd0} < acc_ff[63:0])) begin
               scale_in = 17'd0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_scale_in = scale_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (next_side) begin
         if (side_ff) begin
            state_in = ST_DONE;
         end else begin
            side_in  = 1'b1;
            state_in = ST_EXP0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         prev_ff       <= 32'sd0;
         mode_ff       <= 1'b0;
         scene_thr_ff  <= cvg_pkg::RST_SCENE_THR;
         self_thr_ff   <= cvg_pkg::RST_SELF_THR;
         scene_coef_ff <= cvg_pkg::RST_SCENE_COEF;
         self_coef_ff  <= cvg_pkg::RST_SELF_COEF;
         min_dist_ff   <= cvg_pkg::RST_MIN_DIST;
         safety_ff     <= cvg_pkg::RST_SAFETY;
         check_rate_ff <= cvg_pkg::RST_CHECK_RATE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         if (csr_valid) begin
            unique case (csr_index)
               cvg_pkg::REG_MODE:       mode_ff       <= csr_data[0];
               cvg_pkg::REG_SCENE_THR:  scene_thr_ff  <= csr_data[30:0];
               cvg_pkg::REG_SELF_THR:   self_thr_ff   <= csr_data[30:0];
               cvg_pkg::REG_SCENE_COEF: scene_coef_ff <= csr_data;
               cvg_pkg::REG_SELF_COEF:  self_coef_ff  <= csr_data;
               cvg_pkg::REG_MIN_DIST:   min_dist_ff   <= csr_data[30:0];
               cvg_pkg::REG_SAFETY:     safety_ff     <= csr_data;
               cvg_pkg::REG_CHECK_RATE: check_rate_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath: no reset needed
   always_ff @(posedge clock) begin
      side_ff      <= side_in;
      scene_ff     <= scene_in;
      self_ff      <= self_in;
      stop_ff      <= stop_in;
      scale_ff     <= scale_in;
      y_ff         <= y_in;
      zero_ff      <= zero_in;
      n_ff         <= n_in;
      r_ff         <= r_in;
      v0_ff        <= v0_in;
      dv_ff        <= dv_in;
      v_ff         <= v_in;
      cur_ff       <= cur_in;
      absdiff_ff   <= absdiff_in;
      acur_ff      <= acur_in;
      den_ff       <= den_in;
      p1_ff        <= p1_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_scale_ff <= rsp_scale_in;
   end

   // Contact forces zero straight to the result stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_in_collision) |=>
         (state_ff == ST_DONE && scale_ff == 17'd0))
      else $error("contact did not force zero scale");

   // Previous distance moves only in the stop-mode decision step
   assert property (@(posedge clock) disable iff (reset)
      (prev_ff != $past(prev_ff)) |-> ($past(state_ff) == ST_STOP1))
      else $error("previous distance changed outside stop mode");

   // A new result is loaded only from the final step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result issued outside the final step");

   // Scale never exceeds full speed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_scale_ff <= cvg_pkg::FULL_SCALE))
      else $error("velocity scale above full speed");

endmodule
